### src/zcd_pkg.sv
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared types and constants of the central directory record parser.
// ----------------------------------------------------------------------------
package zcd_pkg;

    localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
    localparam int          FIXED_LEN    = 46;

    // record offsets inside the fixed header
    localparam logic [17:0] POS_SIG_LAST = 18'd3;
    localparam logic [17:0] POS_FIX_LAST = 18'(FIXED_LEN - 1);
    localparam logic [18:0] REC_END_MIN  = 19'(FIXED_LEN);
    localparam logic [18:0] ZERO_CNT_LEN = 19'd4;

    // status codes of a result word
    localparam logic [1:0] ST_ENTRY   = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_DIR_OFFSET  = 1'b1;

    typedef enum logic [2:0] {
        PH_RUN  = 3'b001,
        PH_DONE = 3'b010,
        PH_HALT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_index;
        logic [15:0] method;
        logic [31:0] compressed_size;
        logic [31:0] uncompressed_size;
        logic [31:0] local_header_offset;
        logic [15:0] name_length;
        logic [32:0] name_offset;
        logic        all_done;
    } t_result;

endpackage

### src/zcd_byte_if.sv
// ----------------------------------------------------------------------------
// zcd_byte_if
// Directory byte channel: valid/ready handshake with one byte per word.
// ----------------------------------------------------------------------------
interface zcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

### src/zcd_result_if.sv
// ----------------------------------------------------------------------------
// zcd_result_if
// Result channel: one parsed entry or error report per word.
// ----------------------------------------------------------------------------
interface zcd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] entry_index;
    logic [15:0] method;
    logic [31:0] compressed_size;
    logic [31:0] uncompressed_size;
    logic [31:0] local_header_offset;
    logic [15:0] name_length;
    logic [32:0] name_offset;
    logic        all_done;

    modport source (
        output valid, input ready,
        output status, output entry_index, output method, output compressed_size,
        output uncompressed_size, output local_header_offset, output name_length,
        output name_offset, output all_done
    );
    modport sink (
        input valid, output ready,
        input status, input entry_index, input method, input compressed_size,
        input uncompressed_size, input local_header_offset, input name_length,
        input name_offset, input all_done
    );
endinterface

### src/zcd_core.sv
// ----------------------------------------------------------------------------
// zcd_core
// Parser state, configuration registers and per-byte result logic.
// ----------------------------------------------------------------------------
module zcd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_in_valid,
    input  zcd_pkg::t_in_word i_in,
    input  logic             i_step,
    output logic             o_res_valid,
    output zcd_pkg::t_result o_res
);

    logic [15:0]     r_entry_count;
    logic [31:0]     r_dir_offset;

    logic [17:0]     r_rec_pos,   n_rec_pos;
    logic [31:0]     r_strm_pos,  n_strm_pos;
    logic [15:0]     r_entries,   n_entries;
    logic [23:0]     r_sig,       n_sig;
    logic [15:0]     r_method,    n_method;
    logic [31:0]     r_csize,     n_csize;
    logic [31:0]     r_usize,     n_usize;
    logic [31:0]     r_lhoff,     n_lhoff;
    logic [15:0]     r_len_name,  n_len_name;
    logic [15:0]     r_len_extra, n_len_extra;
    logic [15:0]     r_len_cmt,   n_len_cmt;
    logic [18:0]     r_rec_end,   n_rec_end;
    logic [31:0]     r_name_pos,  n_name_pos;
    zcd_pkg::t_phase r_phase,     n_phase;

    logic [18:0] np;
    logic [31:0] sig_full;
    logic        complete;
    logic [16:0] next_idx;
    logic        done;
    logic [31:0] name_pos;
    logic        rearm;
    logic        res_valid;
    logic [7:0]  b;

    assign b = i_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_dir_offset  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                zcd_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[15:0];
                zcd_pkg::CFG_DIR_OFFSET:  r_dir_offset  <= i_cfg_data;
                default:                  r_dir_offset  <= r_dir_offset;
            endcase
        end
    end

    always_comb begin
        n_rec_pos   = r_rec_pos;
        n_strm_pos  = r_strm_pos;
        n_entries   = r_entries;
        n_sig       = r_sig;
        n_method    = r_method;
        n_csize     = r_csize;
        n_usize     = r_usize;
        n_lhoff     = r_lhoff;
        n_len_name  = r_len_name;
        n_len_extra = r_len_extra;
        n_len_cmt   = r_len_cmt;
        n_name_pos  = r_name_pos;
        n_phase     = r_phase;
        o_res       = '0;
        res_valid   = 1'b0;
        rearm       = 1'b0;
        np          = {1'b0, r_rec_pos} + 19'd1;
        sig_full    = {b, r_sig};
        complete    = np >= r_rec_end;
        next_idx    = {1'b0, r_entries} + 17'd1;
        done        = next_idx >= {1'b0, r_entry_count};
        name_pos    = (r_rec_pos == zcd_pkg::POS_FIX_LAST) ? r_strm_pos + 32'd1 : r_name_pos;

        if (r_phase != zcd_pkg::PH_RUN) begin
            // halted or finished: drop bytes until end of data
            rearm = i_in.end_of_data;
        end else if (r_entry_count == 16'd0) begin
            n_rec_pos  = np[17:0];
            n_strm_pos = r_strm_pos + 32'd1;
            if (np >= zcd_pkg::ZERO_CNT_LEN) begin
                res_valid      = 1'b1;
                o_res.all_done = 1'b1;
                n_phase        = zcd_pkg::PH_DONE;
                rearm          = i_in.end_of_data;
            end else if (i_in.end_of_data) begin
                res_valid         = 1'b1;
                o_res.status      = zcd_pkg::ST_TRUNC;
                o_res.entry_index = r_entries;
                rearm             = 1'b1;
            end
        end else begin
            if (r_rec_pos < 18'd4) begin
                n_sig = {b, r_sig[23:8]};
            end
            if (r_rec_pos[17:6] == 12'd0) begin
                case (r_rec_pos[5:0])
                    6'd10:   n_method          = {8'h00, b};
                    6'd11:   n_method[15:8]    = b;
                    6'd20:   n_csize           = {24'h0, b};
                    6'd21:   n_csize[15:8]     = b;
                    6'd22:   n_csize[23:16]    = b;
                    6'd23:   n_csize[31:24]    = b;
                    6'd24:   n_usize           = {24'h0, b};
                    6'd25:   n_usize[15:8]     = b;
                    6'd26:   n_usize[23:16]    = b;
                    6'd27:   n_usize[31:24]    = b;
                    6'd28:   n_len_name        = {8'h00, b};
                    6'd29:   n_len_name[15:8]  = b;
                    6'd30:   n_len_extra       = {8'h00, b};
                    6'd31:   n_len_extra[15:8] = b;
                    6'd32:   n_len_cmt         = {8'h00, b};
                    6'd33:   n_len_cmt[15:8]   = b;
                    6'd42:   n_lhoff           = {24'h0, b};
                    6'd43:   n_lhoff[15:8]     = b;
                    6'd44:   n_lhoff[23:16]    = b;
                    6'd45:   n_lhoff[31:24]    = b;
                    default: n_method          = n_method;
                endcase
            end
            n_strm_pos = r_strm_pos + 32'd1;
            n_name_pos = name_pos;

            if (!complete && i_in.end_of_data) begin
                res_valid         = 1'b1;
                o_res.status      = zcd_pkg::ST_TRUNC;
                o_res.entry_index = r_entries;
                rearm             = 1'b1;
            end else if (r_rec_pos == zcd_pkg::POS_SIG_LAST &&
                         sig_full != zcd_pkg::CD_SIGNATURE) begin
                res_valid         = 1'b1;
                o_res.status      = zcd_pkg::ST_BAD_SIG;
                o_res.entry_index = r_entries;
                n_phase           = zcd_pkg::PH_HALT;
            end else if (!complete) begin
                n_rec_pos = np[17:0];
            end else if (i_in.end_of_data && !done) begin
                // next record is cut off: report it instead of this one
                res_valid         = 1'b1;
                o_res.status      = zcd_pkg::ST_TRUNC;
                o_res.entry_index = next_idx[15:0];
                rearm             = 1'b1;
            end else begin
                res_valid                 = 1'b1;
                o_res.status              = zcd_pkg::ST_ENTRY;
                o_res.entry_index         = r_entries;
                o_res.method              = n_method;
                o_res.compressed_size     = n_csize;
                o_res.uncompressed_size   = n_usize;
                o_res.local_header_offset = n_lhoff;
                o_res.name_length         = n_len_name;
                o_res.name_offset         = {1'b0, r_dir_offset} + {1'b0, name_pos};
                o_res.all_done            = done;
                n_entries   = next_idx[15:0];
                n_rec_pos   = '0;
                n_sig       = '0;
                n_method    = '0;
                n_csize     = '0;
                n_usize     = '0;
                n_lhoff     = '0;
                n_len_name  = '0;
                n_len_extra = '0;
                n_len_cmt   = '0;
                if (done) begin
                    n_phase = zcd_pkg::PH_DONE;
                end
                rearm = i_in.end_of_data;
            end
        end

        if (rearm) begin
            n_rec_pos   = '0;
            n_strm_pos  = '0;
            n_entries   = '0;
            n_sig       = '0;
            n_method    = '0;
            n_csize     = '0;
            n_usize     = '0;
            n_lhoff     = '0;
            n_len_name  = '0;
            n_len_extra = '0;
            n_len_cmt   = '0;
            n_phase     = zcd_pkg::PH_RUN;
        end

        // end of the current record: fixed header plus variable part
        n_rec_end = zcd_pkg::REC_END_MIN + {3'b000, n_len_name}
                    + {3'b000, n_len_extra} + {3'b000, n_len_cmt};
    end

    assign o_res_valid = i_in_valid && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_pos   <= '0;
            r_strm_pos  <= '0;
            r_entries   <= '0;
            r_sig       <= '0;
            r_method    <= '0;
            r_csize     <= '0;
            r_usize     <= '0;
            r_lhoff     <= '0;
            r_len_name  <= '0;
            r_len_extra <= '0;
            r_len_cmt   <= '0;
            r_rec_end   <= zcd_pkg::REC_END_MIN;
            r_name_pos  <= '0;
            r_phase     <= zcd_pkg::PH_RUN;
        end else if (i_step) begin
            r_rec_pos   <= n_rec_pos;
            r_strm_pos  <= n_strm_pos;
            r_entries   <= n_entries;
            r_sig       <= n_sig;
            r_method    <= n_method;
            r_csize     <= n_csize;
            r_usize     <= n_usize;
            r_lhoff     <= n_lhoff;
            r_len_name  <= n_len_name;
            r_len_extra <= n_len_extra;
            r_len_cmt   <= n_len_cmt;
            r_rec_end   <= n_rec_end;
            r_name_pos  <= n_name_pos;
            r_phase     <= n_phase;
        end
    end

endmodule

### src/zcd_out_stage.sv
// ----------------------------------------------------------------------------
// zcd_out_stage
// Result register that drives the result channel.
// ----------------------------------------------------------------------------
module zcd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  zcd_pkg::t_result  i_res,
    output logic              o_free,
    zcd_result_if.source      o_result
);

    logic             r_valid;
    zcd_pkg::t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid               = r_valid;
    assign o_result.status              = r_res.status;
    assign o_result.entry_index         = r_res.entry_index;
    assign o_result.method              = r_res.method;
    assign o_result.compressed_size     = r_res.compressed_size;
    assign o_result.uncompressed_size   = r_res.uncompressed_size;
    assign o_result.local_header_offset = r_res.local_header_offset;
    assign o_result.name_length         = r_res.name_length;
    assign o_result.name_offset         = r_res.name_offset;
    assign o_result.all_done            = r_res.all_done;

endmodule

### src/zip_central_directory_parser_top.sv
// ----------------------------------------------------------------------------
// zip_central_directory_parser_top
// Byte-serial parser of ZIP central directory records.
// ----------------------------------------------------------------------------
// Feed the central directory one byte per word, starting at the directory
// offset, with end_of_data set on the last byte of the buffer. Each record
// gives one result word when its last byte arrives; errors give a status 1
// (bad signature) or 2 (truncated) word and the parser then drops bytes up to
// end_of_data, which re-arms it. Throughput is one byte per clock while the
// result register can take each due result word, else the input stalls. A byte
// passes an input register, field capture and record-length compare, and a
// result register. Write entry_count and directory_offset only while idle.
module zip_central_directory_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zcd_byte_if.sink    i_byte,
    zcd_result_if.source o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic              r_in_valid;
    zcd_pkg::t_in_word r_in;
    logic              step;
    logic              res_valid;
    zcd_pkg::t_result  res;
    logic              out_free;

    // advance when the result slot can take the word, or no word is due
    assign step         = r_in_valid && (out_free || !res_valid);
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in.data_byte   <= i_byte.data_byte;
            r_in.end_of_data <= i_byte.end_of_data;
        end
    end

    zcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (r_in_valid),
        .i_in        (r_in),
        .i_step      (step),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    zcd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule
